FILE: hw/rtl/dnsrp_pkg.sv
// Shared types, codes and constants of the DNS record parser.
package dnsrp_pkg;

    localparam int PACKET_BYTES_DEF = 512;
    localparam int NAME_BYTES_DEF   = 256;

    localparam logic [7:0]  PTR_MARK          = 8'hC0;
    localparam logic [13:0] PTR_MASK          = 14'h3FFF;
    localparam logic [9:0]  OFFSET_CAP        = 10'd512;
    localparam logic [15:0] RDATA_LIMIT_RESET = 16'd10000;
    localparam logic [7:0]  JUMP_LIMIT_RESET  = 8'd16;
    localparam logic [3:0]  FIELDS_QUESTION   = 4'd4;
    localparam logic [3:0]  FIELDS_RECORD     = 4'd10;
    localparam logic [3:0]  RDATA_SKIP        = 4'd10;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_PARSE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_PAST_END  = 3'd1,
        ST_JUMPS     = 3'd2,
        ST_NAME_LONG = 3'd3,
        ST_OVERSIZE  = 3'd4
    } status_t;

    typedef enum logic [0:0] {
        CFG_RDATA_LIMIT = 1'd0,
        CFG_JUMP_LIMIT  = 1'd1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0] action;
        logic [8:0] byte_address;
        logic [7:0] byte_value;
        logic       entry_kind;
        logic [7:0] name_index;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] record_type;
        logic [15:0] record_class;
        logic [31:0] time_to_live;
        logic [15:0] rdata_length;
        logic [9:0]  rdata_offset;
        logic [9:0]  next_offset;
        logic [8:0]  name_length;
        logic        was_compressed;
        logic [7:0]  name_byte;
    } res_t;

    typedef struct packed {
        logic       en;
        logic [8:0] addr;
        logic [7:0] data;
    } pkt_wr_t;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } name_wr_t;

    // Walk position: holds any 14-bit pointer target and a label step past the store end.
    function automatic int pos_width(input int packet_bytes);
        int w;
        w = $clog2(packet_bytes) + 2;
        return (w > 15) ? w : 15;
    endfunction

    function automatic int len_width(input int packet_bytes);
        return $clog2(packet_bytes + 1);
    endfunction

endpackage

FILE: hw/rtl/dnsrp_if.sv
// Valid/ready channel carrying one word of a given payload type.
interface dnsrp_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hw/rtl/dnsrp_packet_buf.sv
// Packet byte store with loaded length and one registered read port.
module dnsrp_packet_buf #(
    parameter int PACKET_BYTES = dnsrp_pkg::PACKET_BYTES_DEF
) (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  dnsrp_pkg::pkt_wr_t                                pkt_wr,
    input  logic [dnsrp_pkg::pos_width(PACKET_BYTES)-1:0]     rd_addr,
    output logic [7:0]                                        rd_data,
    output logic                                              rd_ok,
    output logic [dnsrp_pkg::len_width(PACKET_BYTES)-1:0]     loaded_length
);
    import dnsrp_pkg::*;

    localparam int AW    = $clog2(PACKET_BYTES);
    localparam int POS_W = pos_width(PACKET_BYTES);
    localparam int LEN_W = len_width(PACKET_BYTES);

    logic [7:0]       mem [PACKET_BYTES];
    logic [7:0]       rd_data_reg;
    logic             rd_ok_reg;
    logic [LEN_W-1:0] loaded_reg;
    logic             wr_in_range;
    logic [POS_W-1:0] wr_top;

    assign wr_in_range = POS_W'(pkt_wr.addr) < POS_W'(PACKET_BYTES);
    assign wr_top      = POS_W'(pkt_wr.addr) + POS_W'(1);

    always_ff @(posedge clk)
    begin
        if (pkt_wr.en && wr_in_range)
        begin
            mem[AW'(pkt_wr.addr)] <= pkt_wr.data;
        end
        rd_data_reg <= mem[rd_addr[AW-1:0]];
    end

    // A byte is readable only below the loaded length, which never exceeds the store.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded_reg <= '0;
            rd_ok_reg  <= 1'b0;
        end
        else
        begin
            rd_ok_reg <= rd_addr < POS_W'(loaded_reg);
            if (pkt_wr.en && wr_in_range && (wr_top > POS_W'(loaded_reg)))
            begin
                loaded_reg <= LEN_W'(wr_top);
            end
        end
    end

    assign rd_data       = rd_data_reg;
    assign rd_ok         = rd_ok_reg;
    assign loaded_length = loaded_reg;
endmodule

FILE: hw/rtl/dnsrp_name_buf.sv
// Decoded name store: one write port, one registered read port.
module dnsrp_name_buf #(
    parameter int NAME_BYTES = dnsrp_pkg::NAME_BYTES_DEF
) (
    input  logic                          clk,
    input  dnsrp_pkg::name_wr_t           name_wr,
    input  logic [$clog2(NAME_BYTES)-1:0] wr_addr,
    input  logic [$clog2(NAME_BYTES)-1:0] rd_addr,
    output logic [7:0]                    rd_data
);
    import dnsrp_pkg::*;

    logic [7:0] mem [NAME_BYTES];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (name_wr.en)
        begin
            mem[wr_addr] <= name_wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
endmodule

FILE: hw/rtl/dnsrp_walker.sv
// Sequencer that walks names byte by byte over the packet read port and builds results.
module dnsrp_walker #(
    parameter int PACKET_BYTES = dnsrp_pkg::PACKET_BYTES_DEF,
    parameter int NAME_BYTES   = dnsrp_pkg::NAME_BYTES_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    dnsrp_if.sink                                         item,
    dnsrp_if.source                                       result,
    input  logic [15:0]                                   rdata_limit,
    input  logic [7:0]                                    jump_limit,
    output dnsrp_pkg::pkt_wr_t                            pkt_wr,
    output logic [dnsrp_pkg::pos_width(PACKET_BYTES)-1:0] fetch_addr,
    input  logic [7:0]                                    pkt_data,
    input  logic                                          pkt_ok,
    input  logic [dnsrp_pkg::len_width(PACKET_BYTES)-1:0] loaded_length,
    output dnsrp_pkg::name_wr_t                           name_wr,
    output logic [$clog2(NAME_BYTES)-1:0]                 name_wr_addr,
    output logic [$clog2(NAME_BYTES)-1:0]                 name_rd_addr,
    input  logic [7:0]                                    name_rd_data
);
    import dnsrp_pkg::*;

    localparam int POS_W  = pos_width(PACKET_BYTES);
    localparam int NEXT_W = POS_W + 2;
    localparam int NW     = $clog2(NAME_BYTES);
    localparam int NL_W   = $clog2(NAME_BYTES + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_NAMERD = 9'b000000010,
        S_HEAD   = 9'b000000100,
        S_PTR    = 9'b000001000,
        S_LABEL  = 9'b000010000,
        S_FIELD  = 9'b000100000,
        S_SUM    = 9'b001000000,
        S_CHECK  = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  end_reg, end_next;
    logic              comp_reg, comp_next;
    logic [7:0]        jumps_reg, jumps_next;
    logic [NL_W-1:0]   nlen_reg, nlen_next;
    logic [7:0]        lab_reg, lab_next;
    logic [5:0]        hi_reg, hi_next;
    logic              kind_reg, kind_next;
    logic [3:0]        fi_reg, fi_next;
    logic              fail_reg, fail_next;
    logic [79:0]       fields_reg, fields_next;
    logic [NEXT_W-1:0] nxt_reg, nxt_next;
    logic [POS_W-1:0]  rdoff_reg, rdoff_next;
    logic              name_ok_reg, name_ok_next;
    res_t              pend_reg, pend_next;
    res_t              res_reg, res_next;
    logic              res_valid_reg, res_valid_next;

    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  ptr_target;
    logic              is_pointer;
    logic              label_too_long;
    logic [15:0]       rec_rdlen;
    logic [3:0]        last_field;
    status_t           check_status;

    function automatic logic [9:0] cap_offset(input logic [NEXT_W-1:0] v);
        return (v > NEXT_W'(OFFSET_CAP)) ? OFFSET_CAP : v[9:0];
    endfunction

    // Result of a name walk that stops early; decoded bytes stay counted.
    function automatic res_t fail_result(input status_t code, input logic [NL_W-1:0] nlen,
                                         input logic comp);
        res_t r;
        r                = '0;
        r.status         = code;
        r.name_length    = 9'(nlen);
        r.was_compressed = comp;
        r.next_offset    = (code == ST_PAST_END) ? OFFSET_CAP : 10'd0;
        return r;
    endfunction

    assign pos_inc        = pos_reg + POS_W'(1);
    assign ptr_target     = POS_W'({hi_reg, pkt_data} & PTR_MASK);
    assign is_pointer     = (pkt_data & PTR_MARK) == PTR_MARK;
    assign label_too_long = (10'(nlen_reg) + 10'(pkt_data) + 10'd2) > 10'(NAME_BYTES);
    assign rec_rdlen      = fields_reg[15:0];
    assign last_field     = kind_reg ? (FIELDS_RECORD - 4'd1) : (FIELDS_QUESTION - 4'd1);

    always_comb
    begin
        if (fail_reg || (nxt_reg > NEXT_W'(loaded_length)))
        begin
            check_status = ST_PAST_END;
        end
        else if (kind_reg && (rec_rdlen > rdata_limit))
        begin
            check_status = ST_OVERSIZE;
        end
        else
        begin
            check_status = ST_OK;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        end_next       = end_reg;
        comp_next      = comp_reg;
        jumps_next     = jumps_reg;
        nlen_next      = nlen_reg;
        lab_next       = lab_reg;
        hi_next        = hi_reg;
        kind_next      = kind_reg;
        fi_next        = fi_reg;
        fail_next      = fail_reg;
        fields_next    = fields_reg;
        nxt_next       = nxt_reg;
        rdoff_next     = rdoff_reg;
        name_ok_next   = name_ok_reg;
        pend_next      = pend_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !result.ready;
        fetch_addr     = pos_reg;
        pkt_wr         = '0;
        name_wr        = '0;
        name_rd_addr   = NW'(item.payload.name_index);

        unique case (state_reg)
            S_IDLE:
            begin
                if (item.valid)
                begin
                    unique case (item.payload.action)
                        ACT_WRITE:
                        begin
                            pkt_wr.en   = 1'b1;
                            pkt_wr.addr = item.payload.byte_address;
                            pkt_wr.data = item.payload.byte_value;
                            pend_next   = '0;
                            state_next  = S_DONE;
                        end
                        ACT_PARSE:
                        begin
                            pos_next   = POS_W'(item.payload.byte_address);
                            fetch_addr = POS_W'(item.payload.byte_address);
                            end_next   = '0;
                            comp_next  = 1'b0;
                            jumps_next = '0;
                            nlen_next  = '0;
                            kind_next  = item.payload.entry_kind;
                            state_next = S_HEAD;
                        end
                        ACT_READ:
                        begin
                            name_ok_next = {1'b0, item.payload.name_index} < 9'(nlen_reg);
                            state_next   = S_NAMERD;
                        end
                        default:
                        begin
                            pend_next  = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_NAMERD:
            begin
                pend_next             = '0;
                pend_next.name_length = 9'(nlen_reg);
                pend_next.name_byte   = name_ok_reg ? name_rd_data : 8'h00;
                state_next            = S_DONE;
            end

            S_HEAD:
            begin
                if (!pkt_ok)
                begin
                    pend_next  = fail_result(ST_PAST_END, nlen_reg, comp_reg);
                    state_next = S_DONE;
                end
                else if (pkt_data == 8'h00)
                begin
                    if (nlen_reg >= NL_W'(NAME_BYTES))
                    begin
                        pend_next  = fail_result(ST_NAME_LONG, nlen_reg, comp_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // Terminator; the fixed fields follow the name or the first pointer.
                        name_wr.en   = 1'b1;
                        name_wr.data = 8'h00;
                        nlen_next    = nlen_reg + NL_W'(1);
                        end_next     = comp_reg ? end_reg : pos_inc;
                        pos_next     = end_next;
                        fetch_addr   = end_next;
                        fi_next      = '0;
                        fail_next    = 1'b0;
                        fields_next  = '0;
                        state_next   = S_FIELD;
                    end
                end
                else if (is_pointer)
                begin
                    hi_next    = pkt_data[5:0];
                    fetch_addr = pos_inc;
                    state_next = S_PTR;
                end
                else if (label_too_long)
                begin
                    pend_next  = fail_result(ST_NAME_LONG, nlen_reg, comp_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    name_wr.en   = 1'b1;
                    name_wr.data = pkt_data;
                    nlen_next    = nlen_reg + NL_W'(1);
                    lab_next     = pkt_data;
                    pos_next     = pos_inc;
                    fetch_addr   = pos_inc;
                    state_next   = S_LABEL;
                end
            end

            S_PTR:
            begin
                if (!pkt_ok)
                begin
                    pend_next  = fail_result(ST_PAST_END, nlen_reg, comp_reg);
                    state_next = S_DONE;
                end
                else if (jumps_reg >= jump_limit)
                begin
                    pend_next  = fail_result(ST_JUMPS, nlen_reg, comp_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    jumps_next = jumps_reg + 8'd1;
                    if (!comp_reg)
                    begin
                        comp_next = 1'b1;
                        end_next  = pos_reg + POS_W'(2);
                    end
                    pos_next   = ptr_target;
                    fetch_addr = ptr_target;
                    state_next = S_HEAD;
                end
            end

            S_LABEL:
            begin
                if (!pkt_ok)
                begin
                    pend_next  = fail_result(ST_PAST_END, nlen_reg, comp_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    name_wr.en   = 1'b1;
                    name_wr.data = pkt_data;
                    nlen_next    = nlen_reg + NL_W'(1);
                    pos_next     = pos_inc;
                    fetch_addr   = pos_inc;
                    if (lab_reg == 8'd1)
                    begin
                        state_next = S_HEAD;
                    end
                    else
                    begin
                        lab_next = lab_reg - 8'd1;
                    end
                end
            end

            S_FIELD:
            begin
                // Bytes past the loaded length read as zero and mark the entry short.
                fields_next = {fields_reg[71:0], (pkt_ok ? pkt_data : 8'h00)};
                if (!pkt_ok)
                begin
                    fail_next = 1'b1;
                end
                if (fi_reg == last_field)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    fi_next    = fi_reg + 4'd1;
                    pos_next   = pos_inc;
                    fetch_addr = pos_inc;
                end
            end

            S_SUM:
            begin
                rdoff_next = end_reg + POS_W'(RDATA_SKIP);
                if (kind_reg)
                begin
                    nxt_next = NEXT_W'(end_reg) + NEXT_W'(RDATA_SKIP) + NEXT_W'(rec_rdlen);
                end
                else
                begin
                    nxt_next = NEXT_W'(end_reg) + NEXT_W'(FIELDS_QUESTION);
                end
                state_next = S_CHECK;
            end

            S_CHECK:
            begin
                pend_next                = '0;
                pend_next.status         = check_status;
                pend_next.name_length    = 9'(nlen_reg);
                pend_next.was_compressed = comp_reg;
                if (kind_reg)
                begin
                    pend_next.record_type  = fields_reg[79:64];
                    pend_next.record_class = fields_reg[63:48];
                    pend_next.time_to_live = fields_reg[47:16];
                    pend_next.rdata_length = rec_rdlen;
                    pend_next.rdata_offset = cap_offset(NEXT_W'(rdoff_reg));
                end
                else
                begin
                    pend_next.record_type  = fields_reg[31:16];
                    pend_next.record_class = fields_reg[15:0];
                end
                pend_next.next_offset = (check_status == ST_PAST_END) ? OFFSET_CAP
                                                                      : cap_offset(nxt_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    res_next       = pend_reg;
                    res_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nlen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nlen_reg      <= nlen_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        end_reg     <= end_next;
        comp_reg    <= comp_next;
        jumps_reg   <= jumps_next;
        lab_reg     <= lab_next;
        hi_reg      <= hi_next;
        kind_reg    <= kind_next;
        fi_reg      <= fi_next;
        fail_reg    <= fail_next;
        fields_reg  <= fields_next;
        nxt_reg     <= nxt_next;
        rdoff_reg   <= rdoff_next;
        name_ok_reg <= name_ok_next;
        pend_reg    <= pend_next;
        res_reg     <= res_next;
    end

    assign name_wr_addr   = nlen_reg[NW-1:0];
    assign item.ready     = (state_reg == S_IDLE);
    assign result.valid   = res_valid_reg;
    assign result.payload = res_reg;
endmodule

FILE: hw/rtl/dns_record_parser.sv
// Top level of the DNS record parser: configuration registers and the parser datapath.
//
//   channel   dir   handshake          word
//   item      in    valid / ready      action, byte_address, byte_value, entry_kind, name_index
//   result    out   valid / ready      status, type, class, TTL, rdata, offsets, name fields
//   cfg       in    cfg_write          cfg_index, cfg_data (no back-pressure)
//
// A packet byte write or an unused action goes straight to the output stage, a name byte read
// through the name store. A parse walks the name byte by byte, follows pointers, reads the 4 or
// 10 fixed field bytes and sums and checks; it all runs through the single packet store read port.
// Reset clears the loaded length and the stored name length and loads the default limits;
// there is no clearing pass.
// The input is held off while a word is in work; a finished word waits in the output
// register and the next word may be taken meanwhile.
module dns_record_parser #(
    parameter int PACKET_BYTES = dnsrp_pkg::PACKET_BYTES_DEF,
    parameter int NAME_BYTES   = dnsrp_pkg::NAME_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    dnsrp_if.sink       item,
    dnsrp_if.source     result,
    input  logic        cfg_write,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import dnsrp_pkg::*;

    localparam int POS_W = pos_width(PACKET_BYTES);
    localparam int LEN_W = len_width(PACKET_BYTES);
    localparam int NW    = $clog2(NAME_BYTES);

    logic [15:0]      rdata_limit_reg;
    logic [7:0]       jump_limit_reg;
    pkt_wr_t          pkt_wr;
    logic [POS_W-1:0] fetch_addr;
    logic [7:0]       pkt_data;
    logic             pkt_ok;
    logic [LEN_W-1:0] loaded_length;
    name_wr_t         name_wr;
    logic [NW-1:0]    name_wr_addr;
    logic [NW-1:0]    name_rd_addr;
    logic [7:0]       name_rd_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdata_limit_reg <= RDATA_LIMIT_RESET;
            jump_limit_reg  <= JUMP_LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RDATA_LIMIT: rdata_limit_reg <= cfg_data;
                CFG_JUMP_LIMIT:  jump_limit_reg  <= cfg_data[7:0];
            endcase
        end
    end

    dnsrp_packet_buf #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_packet_buf (
        .clk           (clk),
        .rst_n         (rst_n),
        .pkt_wr        (pkt_wr),
        .rd_addr       (fetch_addr),
        .rd_data       (pkt_data),
        .rd_ok         (pkt_ok),
        .loaded_length (loaded_length)
    );

    dnsrp_name_buf #(
        .NAME_BYTES (NAME_BYTES)
    ) u_name_buf (
        .clk     (clk),
        .name_wr (name_wr),
        .wr_addr (name_wr_addr),
        .rd_addr (name_rd_addr),
        .rd_data (name_rd_data)
    );

    dnsrp_walker #(
        .PACKET_BYTES (PACKET_BYTES),
        .NAME_BYTES   (NAME_BYTES)
    ) u_walker (
        .clk           (clk),
        .rst_n         (rst_n),
        .item          (item),
        .result        (result),
        .rdata_limit   (rdata_limit_reg),
        .jump_limit    (jump_limit_reg),
        .pkt_wr        (pkt_wr),
        .fetch_addr    (fetch_addr),
        .pkt_data      (pkt_data),
        .pkt_ok        (pkt_ok),
        .loaded_length (loaded_length),
        .name_wr       (name_wr),
        .name_wr_addr  (name_wr_addr),
        .name_rd_addr  (name_rd_addr),
        .name_rd_data  (name_rd_data)
    );
endmodule

FILE: test/dns_record_parser_tb.sv
// Self-checking testbench of the DNS record parser: random and directed words against a predictor.
module dns_record_parser_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dnsrp_pkg::*;

    localparam int PKT              = PACKET_BYTES_DEF;
    localparam int NAMEB            = NAME_BYTES_DEF;
    localparam int REQ_W            = $bits(req_t);
    localparam int CYCLE_LIMIT      = 4_000_000;
    localparam int TAIL_CYCLES      = 64;
    localparam int SHOWN_MISMATCHES = 10;
    localparam int PHASE_WORDS      = 160;
    localparam int KEPT_ENTRIES     = 32;

    // Mirror of the packet and name stores; predicts the result word of every accepted word.
    class dns_parse_tracker;
        logic [7:0]  packet [PKT];
        logic [7:0]  name_buf [NAMEB];
        int unsigned loaded;
        int unsigned name_len;
        int unsigned rdata_limit;
        int unsigned jump_limit;
        res_t        pending [$];
        int unsigned failures;

        function new();
            loaded      = 0;
            name_len    = 0;
            rdata_limit = RDATA_LIMIT_RESET;
            jump_limit  = JUMP_LIMIT_RESET;
            failures    = 0;
        endfunction

        function void set_reg(cfg_reg_t r, logic [15:0] v);
            if (r == CFG_RDATA_LIMIT)
                rdata_limit = v;
            else
                jump_limit = v[7:0];
        endfunction

        function bit fetch(input int unsigned p, output logic [7:0] v);
            v = '0;
            if (p >= loaded || p >= PKT)
                return 1'b0;
            v = packet[p];
            return 1'b1;
        endfunction

        function logic [9:0] clamp_offset(int unsigned v);
            return (v > OFFSET_CAP) ? OFFSET_CAP : 10'(v);
        endfunction

        function res_t walk_entry(int unsigned start, bit kind);
            res_t        r;
            status_t     st;
            logic [7:0]  b;
            logic [7:0]  lo;
            logic [7:0]  c;
            logic [7:0]  fx [10];
            int unsigned pos;
            int unsigned term_end;
            int unsigned jumps;
            int unsigned nlen;
            int unsigned cnt;
            int unsigned nxt;
            int unsigned rdoff;
            int unsigned rdlen;
            int unsigned ttl;
            bit          comp;
            r        = '0;
            st       = ST_OK;
            pos      = start;
            term_end = 0;
            jumps    = 0;
            nlen     = 0;
            comp     = 1'b0;
            forever
            begin
                if (!fetch(pos, b))
                begin
                    st = ST_PAST_END;
                    break;
                end
                if (b == 8'h00)
                begin
                    if (nlen >= NAMEB)
                    begin
                        st = ST_NAME_LONG;
                        break;
                    end
                    name_buf[nlen] = 8'h00;
                    nlen++;
                    if (!comp)
                        term_end = pos + 1;
                    break;
                end
                if ((b & PTR_MARK) == PTR_MARK)
                begin
                    if (!fetch(pos + 1, lo))
                    begin
                        st = ST_PAST_END;
                        break;
                    end
                    if (jumps >= jump_limit)
                    begin
                        st = ST_JUMPS;
                        break;
                    end
                    jumps++;
                    // The entry ends right after the first pointer, wherever the walk goes.
                    if (!comp)
                    begin
                        comp     = 1'b1;
                        term_end = pos + 2;
                    end
                    pos = {b, lo} & {2'b00, PTR_MASK};
                    continue;
                end
                // Lengths 0x40..0xBF are taken as plain labels.
                if (nlen + b + 2 > NAMEB)
                begin
                    st = ST_NAME_LONG;
                    break;
                end
                name_buf[nlen] = b;
                nlen++;
                for (int unsigned i = 0; i < b; i++)
                begin
                    if (!fetch(pos + 1 + i, c))
                    begin
                        st = ST_PAST_END;
                        break;
                    end
                    name_buf[nlen] = c;
                    nlen++;
                end
                if (st != ST_OK)
                    break;
                pos += b + 1;
            end
            name_len         = nlen;
            r.name_length    = 9'(nlen);
            r.was_compressed = comp;
            if (st != ST_OK)
            begin
                r.status      = st;
                r.next_offset = (st == ST_PAST_END) ? OFFSET_CAP : 10'd0;
                return r;
            end

            cnt   = kind ? FIELDS_RECORD : FIELDS_QUESTION;
            rdoff = 0;
            rdlen = 0;
            ttl   = 0;
            for (int i = 0; i < 10; i++)
                fx[i] = '0;
            for (int unsigned i = 0; i < cnt; i++)
                if (!fetch(term_end + i, fx[i]))
                    st = ST_PAST_END;
            if (kind)
            begin
                ttl   = {fx[4], fx[5], fx[6], fx[7]};
                rdlen = {fx[8], fx[9]};
                rdoff = term_end + RDATA_SKIP;
                nxt   = rdoff + rdlen;
            end
            else
                nxt = term_end + FIELDS_QUESTION;
            if (st == ST_OK && nxt > loaded)
                st = ST_PAST_END;
            if (st == ST_OK && kind && rdlen > rdata_limit)
                st = ST_OVERSIZE;
            if (st == ST_PAST_END)
                nxt = OFFSET_CAP;
            r.status       = st;
            r.record_type  = {fx[0], fx[1]};
            r.record_class = {fx[2], fx[3]};
            r.time_to_live = ttl;
            r.rdata_length = 16'(rdlen);
            r.rdata_offset = clamp_offset(rdoff);
            r.next_offset  = clamp_offset(nxt);
            return r;
        endfunction

        function void note_item(req_t w);
            res_t r;
            r = '0;
            case (w.action)
                ACT_WRITE:
                begin
                    packet[w.byte_address] = w.byte_value;
                    if (int'(w.byte_address) + 1 > loaded)
                        loaded = int'(w.byte_address) + 1;
                end
                ACT_PARSE: r = walk_entry(w.byte_address, w.entry_kind);
                ACT_READ:
                begin
                    r.name_length = 9'(name_len);
                    if (w.name_index < name_len)
                        r.name_byte = name_buf[w.name_index];
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function string show(res_t r);
            return $sformatf({"st=%0d type=%h class=%h ttl=%h rdlen=%h rdoff=%0d next=%0d",
                              " nlen=%0d comp=%b byte=%h"},
                             r.status, r.record_type, r.record_class, r.time_to_live,
                             r.rdata_length, r.rdata_offset, r.next_offset, r.name_length,
                             r.was_compressed, r.name_byte);
        endfunction

        function void flag(string what, res_t want, res_t got);
            failures++;
            if (failures <= SHOWN_MISMATCHES)
            begin
                $display("%0t: %s", $time, what);
                $display("    expected %s", show(want));
                $display("    actual   %s", show(got));
            end
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (pending.size() == 0)
            begin
                flag("result word with no prediction pending", '0, got);
                return;
            end
            want = pending.pop_front();
            if (got.status !== want.status || got.record_type !== want.record_type ||
                got.record_class !== want.record_class ||
                got.time_to_live !== want.time_to_live ||
                got.rdata_length !== want.rdata_length ||
                got.rdata_offset !== want.rdata_offset ||
                got.next_offset !== want.next_offset ||
                got.name_length !== want.name_length ||
                got.was_compressed !== want.was_compressed ||
                got.name_byte !== want.name_byte)
                flag("result word mismatch", want, got);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [0:0]  cfg_index;
    logic [15:0] cfg_data;

    dnsrp_if #(.payload_t(req_t)) item_ch ();
    dnsrp_if #(.payload_t(res_t)) result_ch ();

    dns_record_parser u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dns_parse_tracker tracker = new();
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned cycles_run = 0;
    int unsigned entry_starts [$];
    bit          entry_kinds [$];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
        cycles_run <= cycles_run + 1;

    initial
    begin
        while (cycles_run < CYCLE_LIMIT)
            @(posedge clk);
        $display("dns_record_parser regression: fail");
        $finish;
    end

    // Result side: check each accepted word, then pick the next ready level.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            tracker.check_result(result_ch.payload);
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Valid is left high after an accept, so back-to-back words never drop it.
    task automatic send_item(input req_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid   <= 1'b1;
        item_ch.payload <= w;
        do
            @(posedge clk);
        while (!item_ch.ready);
        tracker.note_item(w);
        items_sent++;
    endtask

    task automatic release_item();
        item_ch.valid <= 1'b0;
    endtask

    // Always lets at least one edge pass, so the released valid settles first.
    task automatic drain();
        do
            @(posedge clk);
        while (tracker.pending.size() != 0);
    endtask

    task automatic write_reg(cfg_reg_t r, logic [15:0] v);
        cfg_write <= 1'b1;
        cfg_index <= r;
        cfg_data  <= v;
        @(posedge clk);
        cfg_write <= 1'b0;
        tracker.set_reg(r, v);
        @(posedge clk);
    endtask

    task automatic put_byte(int unsigned a, logic [7:0] v);
        req_t w;
        w              = req_t'(REQ_W'($urandom));
        w.action       = ACT_WRITE;
        w.byte_address = 9'(a);
        w.byte_value   = v;
        send_item(w);
    endtask

    task automatic parse_at(int unsigned a, bit kind);
        req_t w;
        w              = req_t'(REQ_W'($urandom));
        w.action       = ACT_PARSE;
        w.byte_address = 9'(a);
        w.entry_kind   = kind;
        send_item(w);
    endtask

    task automatic read_name(int unsigned idx);
        req_t w;
        w            = req_t'(REQ_W'($urandom));
        w.action     = ACT_READ;
        w.name_index = 8'(idx);
        send_item(w);
    endtask

    function automatic void add_pointer(ref logic [7:0] img [$], input int unsigned target);
        img.push_back(PTR_MARK | 8'(target >> 8));
        img.push_back(8'(target));
    endfunction

    function automatic void add_half(ref logic [7:0] img [$], input logic [15:0] v);
        img.push_back(v[15:8]);
        img.push_back(v[7:0]);
    endfunction

    function automatic logic [15:0] pick16();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // One round: lay down an entry at or below the loaded end, parse it, then poke around.
    task automatic run_round();
        logic [7:0]  img [$];
        req_t        w;
        int unsigned top;
        int unsigned base;
        int unsigned target;
        int unsigned style;
        int unsigned len;
        int unsigned rdlen;
        int unsigned pick;
        int unsigned k;
        bit          kind;
        if ($urandom_range(11) == 0)
        begin
            release_item();
            drain();
        end
        // Writes never go past the loaded end, so every loaded byte has been written.
        top    = (tracker.loaded >= PKT) ? PKT - 1 : tracker.loaded;
        base   = $urandom_range(1) ? top : $urandom_range(top);
        target = (entry_starts.size() != 0 && $urandom_range(1)) ?
                 entry_starts[$urandom_range(entry_starts.size() - 1)] : $urandom_range(top);
        style  = $urandom_range(99);
        if (style < 60)
        begin
            repeat ($urandom_range(4))
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(63, 11) : $urandom_range(10, 1);
                img.push_back(8'(len));
                repeat (len) img.push_back(8'($urandom));
            end
            if ($urandom_range(2) == 0)
                add_pointer(img, target);
            else
                img.push_back(8'h00);
        end
        else if (style < 70)
            add_pointer(img, target);
        else if (style < 80)
        begin
            // A long label pointing back at itself grows the name until it is too long
            // or the pointer budget runs out.
            len = $urandom_range(1) ? $urandom_range(63, 40) : $urandom_range(8'hBF, 8'h40);
            img.push_back(8'(len));
            repeat (len) img.push_back(8'($urandom));
            add_pointer(img, base);
        end
        else if (style < 86)
            add_pointer(img, base);
        else if (style < 92)
        begin
            img.push_back(8'($urandom_range(8'hFF, 8'hC0)));
            img.push_back(8'($urandom));
        end
        else
            repeat ($urandom_range(6, 1)) img.push_back(8'($urandom));

        kind = 1'($urandom_range(1));
        add_half(img, pick16());
        add_half(img, pick16());
        if (kind)
        begin
            add_half(img, pick16());
            add_half(img, pick16());
            pick  = $urandom_range(99);
            rdlen = (pick < 75) ? $urandom_range(6) :
                    (pick < 85) ? $urandom_range(24, 7) : $urandom_range(16'hFFFF);
            add_half(img, 16'(rdlen));
            if (rdlen <= 24)
                repeat (rdlen) img.push_back(8'($urandom));
        end
        for (k = 0; k < img.size() && base + k < PKT; k++)
            put_byte(base + k, img[k]);

        entry_starts.push_back(base);
        entry_kinds.push_back(kind);
        if (entry_starts.size() > KEPT_ENTRIES)
        begin
            void'(entry_starts.pop_front());
            void'(entry_kinds.pop_front());
        end
        parse_at(base, kind);

        repeat ($urandom_range(14, 6))
        begin
            pick = $urandom_range(99);
            top  = (tracker.loaded >= PKT) ? PKT - 1 : tracker.loaded;
            if (pick < 40)
            begin
                k = $urandom_range(entry_starts.size() - 1);
                parse_at(entry_starts[k],
                         ($urandom_range(4) == 0) ? !entry_kinds[k] : entry_kinds[k]);
            end
            else if (pick < 70)
            begin
                k = tracker.name_len + 1;
                read_name($urandom_range(1) ? $urandom_range((k > 255) ? 255 : k) :
                                              $urandom_range(255));
            end
            else if (pick < 78)
                parse_at($urandom_range(PKT - 1), 1'($urandom_range(1)));
            else if (pick < 88)
                put_byte($urandom_range(top), 8'($urandom));
            else if (pick < 93)
            begin
                w        = req_t'(REQ_W'($urandom));
                w.action = ACT_NONE;
                send_item(w);
            end
            else
                put_byte(top, 8'($urandom));
        end
    endtask

    task automatic run_phase(logic [15:0] rlim, logic [15:0] jlim, int unsigned idle,
                             int unsigned stall);
        int unsigned end_at;
        release_item();
        drain();
        write_reg(CFG_RDATA_LIMIT, rlim);
        write_reg(CFG_JUMP_LIMIT, jlim);
        send_idle_pct = idle;
        stall_pct     = stall;
        end_at        = items_sent + PHASE_WORDS;
        while (items_sent < end_at)
            run_round();
    endtask

    initial
    begin
        int unsigned end_at;
        rst_n           <= 1'b0;
        cfg_write       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        item_ch.valid   <= 1'b0;
        item_ch.payload <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty store: parse runs past the end, read returns zero, unused action answers with an all-zero word.
        parse_at(PKT - 1, 1'b1);
        read_name(255);
        send_item('1);
        // A pointer to itself trips the jump limit.
        put_byte(0, PTR_MARK);
        put_byte(1, 8'h00);
        parse_at(0, 1'b0);
        // One-byte label then a record with every fixed field at its top value but the class, which is 1.
        put_byte(2, 8'h01);
        put_byte(3, 8'hFF);
        put_byte(4, 8'h00);
        put_byte(5, 8'hFF);
        put_byte(6, 8'hFF);
        put_byte(7, 8'h00);
        put_byte(8, 8'h01);
        for (int i = 9; i < 15; i++)
            put_byte(i, 8'hFF);
        parse_at(2, 1'b1);
        parse_at(2, 1'b0);
        read_name(1);
        read_name(3);
        // Pointer to the highest 14-bit offset, far beyond the store.
        put_byte(15, 8'hFF);
        put_byte(16, 8'hFF);
        parse_at(15, 1'b0);
        // Hold the sender until the block has caught up completely.
        release_item();
        drain();

        end_at = items_sent + PHASE_WORDS - 20;
        while (items_sent < end_at)
            run_round();

        run_phase(16'd0, 16'd1, 59, 0);
        run_phase(16'hFFFF, 16'd255, 0, 59);
        run_phase(16'($urandom_range(16)), 16'd0, 11, 11);
        run_phase(16'($urandom), 16'($urandom_range(8, 1)), 0, 0);
        run_phase(RDATA_LIMIT_RESET, 16'(JUMP_LIMIT_RESET), 59, 0);
        run_phase(16'($urandom_range(40)), 16'($urandom_range(255, 1)), 0, 59);
        run_phase(16'($urandom), 16'($urandom_range(4, 1)), 11, 11);

        release_item();
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.pending.size() == 0 && tracker.failures == 0)
            $display("dns_record_parser regression: pass");
        else
            $display("dns_record_parser regression: fail");
        $finish;
    end
endmodule
